// ----- src/aod_pkg.sv -----
package aod_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEFT_W  = 25;
   localparam int TYPE_W  = 4;
   localparam int SIZE_W  = 56;
   localparam int HLEN_W  = 4;
   localparam int ERR_W   = 2;
   localparam int PHASE_W = 3;
   localparam int SHIFT_W = 6;

   // Largest frame length; larger byte counts saturate to it.
   localparam longint unsigned FRAME_BYTES_MAX = 64'd16777216;

   localparam int LEB_BYTES_MAX_DEF = 8;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [PHASE_W-1:0] PH_HDR = 3'd0;
   localparam logic [PHASE_W-1:0] PH_EXT = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEB = 3'd2;
   localparam logic [PHASE_W-1:0] PH_PAY = 3'd3;
   localparam logic [PHASE_W-1:0] PH_ERR = 3'd4;

   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERSIZE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_CUT      = 2'd2;
   localparam logic [ERR_W-1:0] ERR_LEB_LONG = 2'd3;

   localparam logic [TYPE_W-1:0] OBU_SEQ_HDR        = 4'd1;
   localparam logic [TYPE_W-1:0] OBU_TYPE_FRAME_HDR = 4'd3;
   localparam logic [TYPE_W-1:0] OBU_TYPE_FRAME     = 4'd6;

   localparam logic [BYTE_W-1:0] LEB_DATA_MASK = 8'h7F;
   localparam logic [BYTE_W-1:0] LEB_CONT_MASK = 8'h80;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic [LEFT_W-1:0] rem;
      logic              last;
      logic              frame_start;
   } entry_type;

   typedef struct packed {
      logic [TYPE_W-1:0] unit_type;
      logic [SIZE_W-1:0] unit_size;
      logic [HLEN_W-1:0] header_bytes;
      logic              key_frame_seen;
      logic              got_sequence;
      logic              got_key;
      logic [ERR_W-1:0]  error_kind;
   } record_type;

endpackage

// ----- src/aod_if.sv -----
interface aod_req_if import aod_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_value;
   logic [LEFT_W-1:0] bytes_left;
   logic              frame_start;

   modport source (output valid, output byte_value, output bytes_left,
                   output frame_start, input ready);
   modport sink   (input valid, input byte_value, input bytes_left,
                   input frame_start, output ready);
endinterface

interface aod_rsp_if import aod_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] unit_type;
   logic [SIZE_W-1:0] unit_size;
   logic [HLEN_W-1:0] header_bytes;
   logic              key_frame_seen;
   logic              got_sequence;
   logic              got_key;
   logic [ERR_W-1:0]  error_kind;

   modport source (output valid, output unit_type, output unit_size,
                   output header_bytes, output key_frame_seen,
                   output got_sequence, output got_key, output error_kind,
                   input ready);
   modport sink   (input valid, input unit_type, input unit_size,
                   input header_bytes, input key_frame_seen,
                   input got_sequence, input got_key, input error_kind,
                   output ready);
endinterface

// ----- src/av1_obu_deframer.sv -----
// Splits a frame, delivered one byte per request on req_ch, into OBU records
// on rsp_ch. Each request carries the byte, the count of frame bytes left
// (this one included) and a frame start flag that clears all parse state.
// A record comes out for the byte that ends an OBU or that reveals an error;
// other bytes give no record. After an error the rest of the frame is
// dropped until the next frame start.
// Throughput is one byte per cycle unless the receiver stalls: the front end
// classifies a byte and writes it into a four-entry queue, and the parser
// behind it updates its state once per cycle, with a 56-bit size compare
// and payload count. With the queue empty, a request is written into a queue
// slot and its record is then registered in the output register behind rsp_ch.valid.
// When the receiver stalls, the record waits in the output register; bytes
// that give no record keep draining, a byte that needs the output waits in
// the queue, and req_ch.ready drops once the queue is full.
// Reset empties the queue and the output register and puts the parser in
// the state that expects a header byte, with both sticky flags cleared.
module av1_obu_deframer import aod_pkg::*; #(
   parameter int LEB_BYTES_MAX = LEB_BYTES_MAX_DEF
) (
   input  logic      clock,
   input  logic      reset,
   aod_req_if.sink   req_ch,
   aod_rsp_if.source rsp_ch
);

   logic      q_full;
   logic      q_push;
   entry_type q_push_entry;
   logic      q_pop;
   logic      q_head_valid;
   entry_type q_head_entry;

   aod_front u_front (
      .req_ch    (req_ch),
      .req_full  (q_full),
      .req_push  (q_push),
      .req_entry (q_push_entry)
   );

   aod_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   aod_back #(
      .LEB_BYTES_MAX (LEB_BYTES_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ----- src/aod_front.sv -----
module aod_front import aod_pkg::*; (
   aod_req_if.sink   req_ch,
   input  logic      req_full,
   output logic      req_push,
   output entry_type req_entry
);

   logic [LEFT_W-1:0] left_sat;

   always_comb begin
      if ({{(64-LEFT_W){1'b0}}, req_ch.bytes_left} > FRAME_BYTES_MAX) begin
         left_sat = LEFT_W'(FRAME_BYTES_MAX);
      end else begin
         left_sat = req_ch.bytes_left;
      end
   end

   // A zero count is taken as the last byte, like a count of one.
   always_comb begin
      req_entry.byte_value  = req_ch.byte_value;
      req_entry.frame_start = req_ch.frame_start;
      if (left_sat == '0) begin
         req_entry.rem = '0;
      end else begin
         req_entry.rem = left_sat - LEFT_W'(1);
      end
      req_entry.last = (req_entry.rem == '0);
   end

   assign req_ch.ready = !req_full;
   assign req_push     = req_ch.valid && !req_full;

endmodule

// ----- src/aod_queue.sv -----
module aod_queue import aod_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/aod_back.sv -----
module aod_back import aod_pkg::*; #(
   parameter int LEB_BYTES_MAX = LEB_BYTES_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   aod_rsp_if.source  rsp_ch
);

   localparam int LEBC_W = $clog2(LEB_BYTES_MAX + 1);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TYPE_W-1:0]  held_type_ff, held_type_in;
   logic               size_flag_ff, size_flag_in;
   logic [SIZE_W-1:0]  size_accum_ff, size_accum_in;
   logic [LEBC_W-1:0]  leb_count_ff, leb_count_in;
   logic [SIZE_W-1:0]  payload_left_ff, payload_left_in;
   logic [HLEN_W-1:0]  head_len_ff, head_len_in;
   logic               key_pending_ff, key_pending_in;
   logic               seq_flag_ff, seq_flag_in;
   logic               key_flag_ff, key_flag_in;
   logic               out_valid_ff;
   record_type         out_rec_ff;

   // State as the byte sees it: a frame start clears everything first.
   logic [PHASE_W-1:0] cur_phase;
   logic [TYPE_W-1:0]  cur_type;
   logic               cur_size_flag;
   logic [SIZE_W-1:0]  cur_accum;
   logic [LEBC_W-1:0]  cur_leb;
   logic [SIZE_W-1:0]  cur_payload;
   logic [HLEN_W-1:0]  cur_head_len;
   logic               cur_key_pending;
   logic               cur_seq;
   logic               cur_key;

   logic [BYTE_W-1:0]  b;
   logic [SIZE_W-1:0]  rem_ext;
   logic [SIZE_W-1:0]  leb_bits;
   logic [SHIFT_W-1:0] shamt;
   logic [SIZE_W-1:0]  fin_size;
   logic [SIZE_W-1:0]  pay_dec;
   logic               do_fin;
   logic               do_end;
   logic               do_err;
   logic [ERR_W-1:0]   err_code;
   logic [SIZE_W-1:0]  err_size;
   logic [SIZE_W-1:0]  end_size;
   logic               produce;
   record_type         rec;

   always_comb begin
      if (head_entry.frame_start) begin
         cur_phase       = PH_HDR;
         cur_type        = '0;
         cur_size_flag   = 1'b0;
         cur_accum       = '0;
         cur_leb         = '0;
         cur_payload     = '0;
         cur_head_len    = '0;
         cur_key_pending = 1'b0;
         cur_seq         = 1'b0;
         cur_key         = 1'b0;
      end else begin
         cur_phase       = phase_ff;
         cur_type        = held_type_ff;
         cur_size_flag   = size_flag_ff;
         cur_accum       = size_accum_ff;
         cur_leb         = leb_count_ff;
         cur_payload     = payload_left_ff;
         cur_head_len    = head_len_ff;
         cur_key_pending = key_pending_ff;
         cur_seq         = seq_flag_ff;
         cur_key         = key_flag_ff;
      end
   end

   always_comb begin
      b        = head_entry.byte_value;
      rem_ext  = {{(SIZE_W-LEFT_W){1'b0}}, head_entry.rem};
      shamt    = SHIFT_W'(cur_leb) * SHIFT_W'(7);
      leb_bits = {{(SIZE_W-BYTE_W){1'b0}}, b & LEB_DATA_MASK} << shamt;

      phase_in        = cur_phase;
      held_type_in    = cur_type;
      size_flag_in    = cur_size_flag;
      size_accum_in   = cur_accum;
      leb_count_in    = cur_leb;
      payload_left_in = cur_payload;
      head_len_in     = cur_head_len;
      key_pending_in  = cur_key_pending;
      seq_flag_in     = cur_seq;
      key_flag_in     = cur_key;

      do_fin   = 1'b0;
      do_end   = 1'b0;
      do_err   = 1'b0;
      err_code = ERR_NONE;
      err_size = '0;
      end_size = '0;
      fin_size = '0;
      pay_dec  = cur_payload;

      case (cur_phase)
         PH_HDR: begin
            held_type_in    = b[6:3];
            size_flag_in    = b[1];
            size_accum_in   = '0;
            leb_count_in    = '0;
            payload_left_in = '0;
            key_pending_in  = 1'b0;
            head_len_in     = HLEN_W'(1);
            if (b[2] || b[1]) begin
               if (head_entry.last) begin
                  do_err   = 1'b1;
                  err_code = ERR_CUT;
               end else begin
                  phase_in = b[2] ? PH_EXT : PH_LEB;
               end
            end else begin
               do_fin = 1'b1;
            end
         end
         PH_EXT: begin
            head_len_in = cur_head_len + HLEN_W'(1);
            if (cur_size_flag) begin
               if (head_entry.last) begin
                  do_err   = 1'b1;
                  err_code = ERR_CUT;
               end else begin
                  phase_in = PH_LEB;
               end
            end else begin
               do_fin = 1'b1;
            end
         end
         PH_LEB: begin
            if (cur_leb >= LEBC_W'(LEB_BYTES_MAX)) begin
               do_err   = 1'b1;
               err_code = ERR_LEB_LONG;
               err_size = cur_accum;
            end else begin
               size_accum_in = cur_accum | leb_bits;
               leb_count_in  = cur_leb + LEBC_W'(1);
               head_len_in   = cur_head_len + HLEN_W'(1);
               if ((b & LEB_CONT_MASK) != '0) begin
                  if (leb_count_in >= LEBC_W'(LEB_BYTES_MAX)) begin
                     do_err   = 1'b1;
                     err_code = ERR_LEB_LONG;
                     err_size = size_accum_in;
                  end else if (head_entry.last) begin
                     do_err   = 1'b1;
                     err_code = ERR_CUT;
                     err_size = size_accum_in;
                  end
               end else begin
                  do_fin = 1'b1;
               end
            end
         end
         PH_PAY: begin
            // The first payload byte of a frame header carries the frame type.
            if (cur_payload == cur_accum &&
                (cur_type == OBU_TYPE_FRAME_HDR || cur_type == OBU_TYPE_FRAME)) begin
               key_pending_in = !b[7] && (b[6:5] == 2'b00);
            end
            if (cur_payload != '0) begin
               pay_dec = cur_payload - SIZE_W'(1);
            end
            payload_left_in = pay_dec;
            if (pay_dec == '0) begin
               do_end   = 1'b1;
               end_size = cur_accum;
            end
         end
         default: begin
            phase_in = PH_ERR;
         end
      endcase

      if (do_fin) begin
         fin_size = size_flag_in ? size_accum_in : rem_ext;
         if (fin_size > rem_ext) begin
            do_err   = 1'b1;
            err_code = ERR_OVERSIZE;
            err_size = fin_size;
         end else begin
            size_accum_in  = fin_size;
            key_pending_in = 1'b0;
            if (fin_size == '0) begin
               do_end   = 1'b1;
               end_size = '0;
            end else begin
               payload_left_in = fin_size;
               phase_in        = PH_PAY;
            end
         end
      end

      if (do_end) begin
         if (held_type_in == OBU_SEQ_HDR) begin
            seq_flag_in = 1'b1;
         end
         if (key_pending_in) begin
            key_flag_in = 1'b1;
         end
         phase_in = PH_HDR;
      end

      if (do_err) begin
         phase_in = PH_ERR;
      end

      produce            = do_end || do_err;
      rec.unit_type      = held_type_in;
      rec.unit_size      = do_err ? err_size : end_size;
      rec.header_bytes   = head_len_in;
      rec.key_frame_seen = do_err ? 1'b0 : key_pending_in;
      rec.got_sequence   = seq_flag_in;
      rec.got_key        = key_flag_in;
      rec.error_kind     = do_err ? err_code : ERR_NONE;
   end

   // A byte that yields no record never waits on the output register.
   assign pop = head_valid && (!produce || !out_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR;
         held_type_ff    <= '0;
         size_flag_ff    <= 1'b0;
         size_accum_ff   <= '0;
         leb_count_ff    <= '0;
         payload_left_ff <= '0;
         head_len_ff     <= '0;
         key_pending_ff  <= 1'b0;
         seq_flag_ff     <= 1'b0;
         key_flag_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff        <= phase_in;
            held_type_ff    <= held_type_in;
            size_flag_ff    <= size_flag_in;
            size_accum_ff   <= size_accum_in;
            leb_count_ff    <= leb_count_in;
            payload_left_ff <= payload_left_in;
            head_len_ff     <= head_len_in;
            key_pending_ff  <= key_pending_in;
            seq_flag_ff     <= seq_flag_in;
            key_flag_ff     <= key_flag_in;
         end
         if (pop && produce) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && produce) begin
         out_rec_ff <= rec;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.unit_type      = out_rec_ff.unit_type;
   assign rsp_ch.unit_size      = out_rec_ff.unit_size;
   assign rsp_ch.header_bytes   = out_rec_ff.header_bytes;
   assign rsp_ch.key_frame_seen = out_rec_ff.key_frame_seen;
   assign rsp_ch.got_sequence   = out_rec_ff.got_sequence;
   assign rsp_ch.got_key        = out_rec_ff.got_key;
   assign rsp_ch.error_kind     = out_rec_ff.error_kind;

endmodule
